// ----- design/matroid_axiom_checker_assert.svh -----
// ----------------------------------------------------------------------------
// matroid_axiom_checker_assert.svh
// Assertion macros used by the checker's top-level RTL file. They expect the
// including scope to have a clock named clk and an active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef MATROID_AXIOM_CHECKER_ASSERT_SVH
`define MATROID_AXIOM_CHECKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MAC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("matroid_axiom_checker: same-cycle assertion failed");

// Next-cycle implication, checked outside reset.
`define MAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("matroid_axiom_checker: next-cycle assertion failed");

`endif

// ----- design/mac_pkg.sv -----
// ----------------------------------------------------------------------------
// mac_pkg
// Types, codes and constants shared by the matroid axiom checker modules.
// ----------------------------------------------------------------------------
package mac_pkg;

  // Default ground set capacity (table holds 2**MAX_GROUND flags)
  localparam int MAX_GROUND_DEF = 10;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int ELEM_W  = 4;
  localparam int GSIZE_W = 4;
  localparam int FAIL_W  = 2;
  // Width of the effective ground size (holds up to 31)
  localparam int NW      = 5;

  localparam logic [GSIZE_W-1:0] GSIZE_RST = 4'd10;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

  // Failure codes
  localparam logic [FAIL_W-1:0] FAIL_NONE  = 2'd0;
  localparam logic [FAIL_W-1:0] FAIL_EMPTY = 2'd1;
  localparam logic [FAIL_W-1:0] FAIL_HERED = 2'd2;
  localparam logic [FAIL_W-1:0] FAIL_EXCH  = 2'd3;

  // Table read address sources
  localparam logic [2:0] RSEL_ZERO    = 3'd0;
  localparam logic [2:0] RSEL_A       = 3'd1;
  localparam logic [2:0] RSEL_A_MINUS = 3'd2;
  localparam logic [2:0] RSEL_B       = 3'd3;
  localparam logic [2:0] RSEL_B_PLUS  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ELEM_W-1:0] element_index;
  } in_item_t;

  typedef struct packed {
    logic              is_matroid;
    logic [FAIL_W-1:0] failed_axiom;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic              clr_we;
    logic              load_elem;
    logic              load_mark;
    logic [2:0]        rd_sel;
    logic              a_clr;
    logic              a_inc;
    logic              b_clr;
    logic              b_inc;
    logic              i_clr;
    logic              i_inc;
    logic              res_load;
    logic [FAIL_W-1:0] res_fail;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic rd_data;
    logic a_last;
    logic b_last;
    logic i_last;
    logic bit_a;
    logic bit_diff;
    logic pop_gt;
  } sts_t;

endpackage

// ----- design/mac_ram.sv -----
// ----------------------------------------------------------------------------
// mac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/mac_dpath.sv -----
// ----------------------------------------------------------------------------
// mac_dpath
// Datapath: ground size register, set accumulator, independence table,
// subset counters and the result register.
// ----------------------------------------------------------------------------
module mac_dpath #(
  parameter int MAX_GROUND = mac_pkg::MAX_GROUND_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mac_pkg::GSIZE_W-1:0]  cfg_data,
  input  mac_pkg::in_item_t            in_data,
  input  mac_pkg::cmd_t                cmd,
  output mac_pkg::sts_t                sts,
  output mac_pkg::out_item_t           out_data
);

  localparam int DEPTH = 1 << MAX_GROUND;
  localparam int IW    = (MAX_GROUND > 1) ? $clog2(MAX_GROUND) : 1;
  localparam int NW    = mac_pkg::NW;

  logic [mac_pkg::GSIZE_W-1:0] gsize_r;
  logic [MAX_GROUND-1:0]       acc_r, acc_nxt;
  logic [MAX_GROUND-1:0]       clr_r, clr_nxt;
  logic [MAX_GROUND-1:0]       a_r, a_nxt;
  logic [MAX_GROUND-1:0]       b_r, b_nxt;
  logic [IW-1:0]               i_r, i_nxt;
  mac_pkg::out_item_t          res_r;

  logic [NW-1:0]         gsz_ext;
  logic [NW-1:0]         n_eff;
  logic [MAX_GROUND-1:0] lim_mask;
  logic [MAX_GROUND-1:0] bit_sel;
  logic [MAX_GROUND-1:0] elem_bit;
  logic                  elem_ok;
  logic [MAX_GROUND-1:0] raddr;
  logic [MAX_GROUND-1:0] waddr;
  logic                  wdata;
  logic                  we;
  logic                  rdata;

  function automatic logic [NW-1:0] pop_count(input logic [MAX_GROUND-1:0] v);
    logic [NW-1:0] c;
    c = '0;
    for (int k = 0; k < MAX_GROUND; k++) begin
      c = c + NW'(v[k]);
    end
    return c;
  endfunction

  // Effective ground size: zero acts as one, above capacity acts as capacity
  assign gsz_ext = NW'(gsize_r);
  always_comb begin
    if (gsz_ext == '0) begin
      n_eff = NW'(1);
    end else if (gsz_ext > NW'(MAX_GROUND)) begin
      n_eff = NW'(MAX_GROUND);
    end else begin
      n_eff = gsz_ext;
    end
  end

  // Mask of all ground elements in use
  always_comb begin
    for (int k = 0; k < MAX_GROUND; k++) begin
      lim_mask[k] = (NW'(k) < n_eff);
    end
  end

  assign bit_sel  = MAX_GROUND'(1) << i_r;
  assign elem_bit = MAX_GROUND'(1) << in_data.element_index;
  assign elem_ok  = (NW'(in_data.element_index) < n_eff);

  // Ground size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r <= mac_pkg::GSIZE_RST;
    end else if (cfg_we) begin
      gsize_r <= cfg_data;
    end
  end

  // Accumulate elements, drop the set once marked
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.load_mark) begin
      acc_nxt = '0;
    end else if (cmd.load_elem && elem_ok) begin
      acc_nxt = acc_r | elem_bit;
    end
  end

  // Advance counters
  always_comb begin
    clr_nxt = cmd.clr_we ? clr_r + MAX_GROUND'(1) : clr_r;
    a_nxt   = cmd.a_clr ? '0 : (cmd.a_inc ? a_r + MAX_GROUND'(1) : a_r);
    b_nxt   = cmd.b_clr ? '0 : (cmd.b_inc ? b_r + MAX_GROUND'(1) : b_r);
    i_nxt   = cmd.i_clr ? '0 : (cmd.i_inc ? i_r + IW'(1) : i_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      clr_r <= '0;
      a_r   <= '0;
      b_r   <= '0;
      i_r   <= '0;
    end else begin
      acc_r <= acc_nxt;
      clr_r <= clr_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      i_r   <= i_nxt;
    end
  end

  // Pick the table read address
  always_comb begin
    case (cmd.rd_sel)
      mac_pkg::RSEL_ZERO:    raddr = '0;
      mac_pkg::RSEL_A:       raddr = a_r;
      mac_pkg::RSEL_A_MINUS: raddr = a_r & ~bit_sel;
      mac_pkg::RSEL_B:       raddr = b_r;
      mac_pkg::RSEL_B_PLUS:  raddr = b_r | bit_sel;
      default:               raddr = '0;
    endcase
  end

  // Table writes: clearing sweep or set mark
  assign we    = cmd.clr_we | cmd.load_mark;
  assign waddr = cmd.clr_we ? clr_r : acc_r;
  assign wdata = ~cmd.clr_we;

  mac_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller
  always_comb begin
    sts.clr_last = &clr_r;
    sts.rd_data  = rdata;
    sts.a_last   = (a_r == lim_mask);
    sts.b_last   = (b_r == lim_mask);
    sts.i_last   = (NW'(i_r) == (n_eff - NW'(1)));
    sts.bit_a    = |(a_r & bit_sel);
    sts.bit_diff = |(a_r & ~b_r & bit_sel);
    sts.pop_gt   = (pop_count(a_r) > pop_count(b_r));
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.is_matroid   <= (cmd.res_fail == mac_pkg::FAIL_NONE);
      res_r.failed_axiom <= cmd.res_fail;
    end
  end

  assign out_data = res_r;

endmodule

// ----- design/mac_ctrl.sv -----
// ----------------------------------------------------------------------------
// mac_ctrl
// Controller: table clearing after reset, load handshake and the sequencer
// that walks the empty-set, hereditary and exchange checks.
// ----------------------------------------------------------------------------
module mac_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [mac_pkg::KIND_W-1:0]  in_kind,
  output logic                        in_stall,
  input  logic                        out_stall,
  output logic                        out_valid,
  output mac_pkg::cmd_t               cmd,
  input  mac_pkg::sts_t               sts
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_EMPTY   = 4'd2;
  localparam logic [3:0] S_EMPTY_W = 4'd3;
  localparam logic [3:0] S_H_A     = 4'd4;
  localparam logic [3:0] S_H_AW    = 4'd5;
  localparam logic [3:0] S_H_I     = 4'd6;
  localparam logic [3:0] S_H_IW    = 4'd7;
  localparam logic [3:0] S_X_A     = 4'd8;
  localparam logic [3:0] S_X_AW    = 4'd9;
  localparam logic [3:0] S_X_B     = 4'd10;
  localparam logic [3:0] S_X_BW    = 4'd11;
  localparam logic [3:0] S_X_I     = 4'd12;
  localparam logic [3:0] S_X_IW    = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]                 state_r, state_nxt;
  logic [mac_pkg::FAIL_W-1:0] fail_r, fail_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    fail_nxt     = fail_r;
    cmd          = '0;
    cmd.rd_sel   = mac_pkg::RSEL_ZERO;
    cmd.res_fail = fail_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            mac_pkg::KIND_ADD:   cmd.load_elem = 1'b1;
            mac_pkg::KIND_END:   cmd.load_mark = 1'b1;
            mac_pkg::KIND_CHECK: state_nxt = S_EMPTY;
            default: ;
          endcase
        end
      end
      S_EMPTY: begin
        cmd.rd_sel = mac_pkg::RSEL_ZERO;
        state_nxt  = S_EMPTY_W;
      end
      S_EMPTY_W: begin
        if (!sts.rd_data) begin
          fail_nxt  = mac_pkg::FAIL_EMPTY;
          state_nxt = S_DONE;
        end else begin
          cmd.a_clr = 1'b1;
          state_nxt = S_H_A;
        end
      end
      // Hereditary pass: every independent set minus any one element
      S_H_A: begin
        cmd.rd_sel = mac_pkg::RSEL_A;
        state_nxt  = S_H_AW;
      end
      S_H_AW: begin
        if (sts.rd_data) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_H_I;
        end else if (sts.a_last) begin
          cmd.a_clr = 1'b1;
          state_nxt = S_X_A;
        end else begin
          cmd.a_inc = 1'b1;
          state_nxt = S_H_A;
        end
      end
      S_H_I: begin
        if (sts.bit_a) begin
          cmd.rd_sel = mac_pkg::RSEL_A_MINUS;
          state_nxt  = S_H_IW;
        end else if (!sts.i_last) begin
          cmd.i_inc = 1'b1;
        end else if (sts.a_last) begin
          cmd.a_clr = 1'b1;
          state_nxt = S_X_A;
        end else begin
          cmd.a_inc = 1'b1;
          state_nxt = S_H_A;
        end
      end
      S_H_IW: begin
        if (!sts.rd_data) begin
          fail_nxt  = mac_pkg::FAIL_HERED;
          state_nxt = S_DONE;
        end else if (!sts.i_last) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_H_I;
        end else if (sts.a_last) begin
          cmd.a_clr = 1'b1;
          state_nxt = S_X_A;
        end else begin
          cmd.a_inc = 1'b1;
          state_nxt = S_H_A;
        end
      end
      // Exchange pass: every pair of independent sets A, B with |A| > |B|
      S_X_A: begin
        cmd.rd_sel = mac_pkg::RSEL_A;
        state_nxt  = S_X_AW;
      end
      S_X_AW: begin
        if (sts.rd_data) begin
          cmd.b_clr = 1'b1;
          state_nxt = S_X_B;
        end else if (sts.a_last) begin
          fail_nxt  = mac_pkg::FAIL_NONE;
          state_nxt = S_DONE;
        end else begin
          cmd.a_inc = 1'b1;
          state_nxt = S_X_A;
        end
      end
      S_X_B: begin
        cmd.rd_sel = mac_pkg::RSEL_B;
        state_nxt  = S_X_BW;
      end
      S_X_BW: begin
        if (sts.rd_data && sts.pop_gt) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_X_I;
        end else if (!sts.b_last) begin
          cmd.b_inc = 1'b1;
          state_nxt = S_X_B;
        end else if (sts.a_last) begin
          fail_nxt  = mac_pkg::FAIL_NONE;
          state_nxt = S_DONE;
        end else begin
          cmd.a_inc = 1'b1;
          state_nxt = S_X_A;
        end
      end
      S_X_I: begin
        if (sts.bit_diff) begin
          cmd.rd_sel = mac_pkg::RSEL_B_PLUS;
          state_nxt  = S_X_IW;
        end else if (!sts.i_last) begin
          cmd.i_inc = 1'b1;
        end else begin
          fail_nxt  = mac_pkg::FAIL_EXCH;
          state_nxt = S_DONE;
        end
      end
      S_X_IW: begin
        if (sts.rd_data) begin
          // Exchange element found: advance to the next B
          if (!sts.b_last) begin
            cmd.b_inc = 1'b1;
            state_nxt = S_X_B;
          end else if (sts.a_last) begin
            fail_nxt  = mac_pkg::FAIL_NONE;
            state_nxt = S_DONE;
          end else begin
            cmd.a_inc = 1'b1;
            state_nxt = S_X_A;
          end
        end else if (!sts.i_last) begin
          cmd.i_inc = 1'b1;
          state_nxt = S_X_I;
        end else begin
          fail_nxt  = mac_pkg::FAIL_EXCH;
          state_nxt = S_DONE;
        end
      end
      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output beat stays until taken
  assign out_valid_nxt = cmd.res_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fail_r <= fail_nxt;
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/matroid_axiom_checker.sv -----
// ----------------------------------------------------------------------------
// matroid_axiom_checker
// Loads a family of subsets and checks the three matroid axioms.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall/in_data) carry a kind and an element index.
// Add-element and end-of-set beats are taken one per cycle while idle and
// give no result. A check beat starts the sequencer; it gives one output
// beat (out_valid/out_stall/out_data) with is_matroid and the first failed
// axiom. The check steps read the independence table RAM, whose single
// registered read port sets the pace. Input stays stalled during a check.
// After reset the table is swept to zero, one entry a cycle, over all
// 2**MAX_GROUND entries (1024 by default); input stays stalled meanwhile.
// cfg_we/cfg_data write the ground size; the user must write it only while
// the block is idle, which the block itself does not enforce.
// A stalled result holds in the output register; load beats keep flowing,
// and a further check waits at its end until that register is free.
// ----------------------------------------------------------------------------
`include "matroid_axiom_checker_assert.svh"

module matroid_axiom_checker #(
  parameter int MAX_GROUND = mac_pkg::MAX_GROUND_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mac_pkg::GSIZE_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mac_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mac_pkg::out_item_t          out_data
);

  mac_pkg::cmd_t cmd;
  mac_pkg::sts_t sts;
  logic          check_beat;
  logic          res_ok;

  mac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  mac_dpath #(
    .MAX_GROUND (MAX_GROUND)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // Accepted check beat and result payload agreement
  assign check_beat = in_valid && !in_stall && (in_data.kind == mac_pkg::KIND_CHECK);
  assign res_ok     = (out_data.is_matroid == (out_data.failed_axiom == mac_pkg::FAIL_NONE));

  // Clearing sweep never overlaps input acceptance or a set mark
  `MAC_ASSERT_IMPLY(a_clr_excl, cmd.clr_we, in_stall && !cmd.load_mark)

  // A check beat blocks the input on the following cycle
  `MAC_ASSERT_NEXT(a_check_stalls, check_beat, in_stall)

  // Pass flag agrees with the failure code whenever out_valid rises
  `MAC_ASSERT_IMPLY(a_res_consistent, $rose(out_valid), res_ok)

endmodule
